[rtl/core/mine_neighbor_count_3x3_top_macros.svh]
// assertion helpers for the mine neighbour counter
`ifndef MINE_NEIGHBOR_COUNT_3X3_TOP_MACROS_SVH
`define MINE_NEIGHBOR_COUNT_3X3_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MNC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MNC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MNC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define MNC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/core/mnc_pkg.sv]
package mnc_pkg;

    localparam int MAX_COLS = 32;
    localparam int MAX_ROWS = 1024;

    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int CNT_W      = 4;
    localparam int BYTE_W     = 8;
    localparam int ROWS_CFG_W = 11;
    localparam int COLS_CFG_W = 6;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    localparam logic [BYTE_W-1:0] MINE_BYTE = 8'h21;

    // register indexes
    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    // which result the datapath builds
    localparam logic [1:0] EMIT_UPPER_LEFT = 2'd0;
    localparam logic [1:0] EMIT_UPPER_EDGE = 2'd1;
    localparam logic [1:0] EMIT_FLUSH      = 2'd2;

    typedef struct packed {
        logic       write_cell;
        logic       emit;
        logic [1:0] emit_kind;
        logic       advance;
        logic       restart;
        logic       flush_inc;
    } mnc_cmd_t;

    typedef struct packed {
        logic need_a;
        logic need_b;
        logic end_row;
        logic last_row;
        logic flush_done;
        logic slot_free;
    } mnc_status_t;

    // mines in the three columns around col over three stored rows
    function automatic logic [CNT_W-1:0] win_sum(
        input logic [MAX_COLS-1:0] top,
        input logic [MAX_COLS-1:0] mid,
        input logic [MAX_COLS-1:0] bot,
        input logic [COL_W-1:0]    col
    );
        logic [MAX_COLS:0] st;
        logic [MAX_COLS:0] sm;
        logic [MAX_COLS:0] sb;
        st = {top, 1'b0} >> col;
        sm = {mid, 1'b0} >> col;
        sb = {bot, 1'b0} >> col;
        return CNT_W'($countones({st[2:0], sm[2:0], sb[2:0]}));
    endfunction

endpackage

[rtl/core/mnc_ctrl.sv]
`include "mine_neighbor_count_3x3_top_macros.svh"

module mnc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mnc_pkg::mnc_status_t status,
    output mnc_pkg::mnc_cmd_t    cmd
);
    import mnc_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EMIT_A = 2'd1;
    localparam logic [1:0] S_EMIT_B = 2'd2;
    localparam logic [1:0] S_FLUSH  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.write_cell = 1'b1;
                    state_next     = S_EMIT_A;
                end
            end
            S_EMIT_A:
            begin
                if (!status.need_a)
                begin
                    state_next = S_EMIT_B;
                end
                else if (status.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_UPPER_LEFT;
                    state_next    = S_EMIT_B;
                end
            end
            S_EMIT_B:
            begin
                if (!status.need_b || status.slot_free)
                begin
                    if (status.need_b)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = EMIT_UPPER_EDGE;
                    end
                    if (status.end_row && status.last_row)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            S_FLUSH:
            begin
                if (status.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_FLUSH;
                    if (status.flush_done)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        cmd.flush_inc = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `MNC_ASSERT_NXT(a_accept_starts_emit, clk, rst_n, in_valid && in_ready,
        state_reg == S_EMIT_A, "accepted item did not start result phase")
    `MNC_ASSERT_IMP(a_emit_needs_slot, clk, rst_n, cmd.emit, status.slot_free,
        "result issued while output register busy")
    `MNC_ASSERT_IMP(a_restart_from_flush, clk, rst_n, cmd.restart,
        state_reg == S_FLUSH && status.flush_done, "frame restart outside flush end")
    `MNC_ASSERT_NXT(a_flush_end_idle, clk, rst_n, cmd.restart,
        state_reg == S_IDLE, "flush end did not return to idle")

endmodule

[rtl/core/mnc_datapath.sv]
module mnc_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [mnc_pkg::BYTE_W-1:0]       cell_byte,
    input  logic [mnc_pkg::ROWS_CFG_W-1:0]   grid_rows,
    input  logic [mnc_pkg::COLS_CFG_W-1:0]   grid_cols,
    input  logic                             cfg_restart,
    input  mnc_pkg::mnc_cmd_t                cmd,
    output mnc_pkg::mnc_status_t             status,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [mnc_pkg::ROW_W-1:0]        out_row,
    output logic [mnc_pkg::COL_W-1:0]        out_col,
    output logic [mnc_pkg::CNT_W-1:0]        mine_count,
    output logic                             frame_last
);
    import mnc_pkg::*;

    logic [MAX_COLS-1:0] row_two_above_reg, row_two_above_next;
    logic [MAX_COLS-1:0] row_above_reg,     row_above_next;
    logic [MAX_COLS-1:0] row_current_reg,   row_current_next;
    logic [ROW_W-1:0]    in_row_reg,        in_row_next;
    logic [COL_W-1:0]    in_col_reg,        in_col_next;
    logic [COL_W-1:0]    flush_col_reg,     flush_col_next;

    logic                out_valid_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic [COL_W-1:0]    out_col_reg;
    logic [CNT_W-1:0]    mine_count_reg;
    logic                frame_last_reg;

    logic [COL_W-1:0]    last_col;
    logic [ROW_W-1:0]    res_row;
    logic [COL_W-1:0]    res_col;
    logic [CNT_W-1:0]    res_count;
    logic                res_last;

    assign last_col = COL_W'(grid_cols - COLS_CFG_W'(1));

    assign status.need_a     = (in_row_reg != '0) && (in_col_reg != '0);
    assign status.need_b     = (in_row_reg != '0) && (in_col_reg == last_col);
    assign status.end_row    = (in_col_reg >= last_col);
    assign status.last_row   = (({1'b0, in_row_reg} + ROWS_CFG_W'(1)) >= grid_rows);
    assign status.flush_done = (flush_col_reg == last_col);
    assign status.slot_free  = !out_valid_reg || out_ready;

    // result builder
    always_comb
    begin
        res_row   = in_row_reg - ROW_W'(1);
        res_col   = in_col_reg - COL_W'(1);
        res_count = '0;
        res_last  = 1'b0;
        case (cmd.emit_kind)
            EMIT_UPPER_LEFT:
            begin
                res_count = win_sum(row_two_above_reg, row_above_reg, row_current_reg,
                                    in_col_reg - COL_W'(1));
            end
            EMIT_UPPER_EDGE:
            begin
                res_col   = in_col_reg;
                res_count = win_sum(row_two_above_reg, row_above_reg, row_current_reg,
                                    in_col_reg);
            end
            EMIT_FLUSH:
            begin
                res_row   = in_row_reg;
                res_col   = flush_col_reg;
                res_count = win_sum(row_above_reg, row_current_reg, '0, flush_col_reg);
                res_last  = (flush_col_reg == last_col);
            end
            default:
            begin
                res_count = '0;
            end
        endcase
    end

    // row stores and positions
    always_comb
    begin
        row_two_above_next = row_two_above_reg;
        row_above_next     = row_above_reg;
        row_current_next   = row_current_reg;
        in_row_next        = in_row_reg;
        in_col_next        = in_col_reg;
        flush_col_next     = flush_col_reg;
        if (cmd.restart || cfg_restart)
        begin
            row_two_above_next = '0;
            row_above_next     = '0;
            row_current_next   = '0;
            in_row_next        = '0;
            in_col_next        = '0;
            flush_col_next     = '0;
        end
        else
        begin
            if (cmd.write_cell)
            begin
                row_current_next[in_col_reg] = (cell_byte == MINE_BYTE);
            end
            if (cmd.advance)
            begin
                if (in_col_reg >= last_col)
                begin
                    row_two_above_next = row_above_reg;
                    row_above_next     = row_current_reg;
                    row_current_next   = '0;
                    in_row_next        = in_row_reg + ROW_W'(1);
                    in_col_next        = '0;
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
            end
            if (cmd.flush_inc)
            begin
                flush_col_next = flush_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_two_above_reg <= '0;
            row_above_reg     <= '0;
            row_current_reg   <= '0;
            in_row_reg        <= '0;
            in_col_reg        <= '0;
            flush_col_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            row_two_above_reg <= row_two_above_next;
            row_above_reg     <= row_above_next;
            row_current_reg   <= row_current_next;
            in_row_reg        <= in_row_next;
            in_col_reg        <= in_col_next;
            flush_col_reg     <= flush_col_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_row_reg    <= res_row;
            out_col_reg    <= res_col;
            mine_count_reg <= res_count;
            frame_last_reg <= res_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign mine_count = mine_count_reg;
    assign frame_last = frame_last_reg;

endmodule

[rtl/core/mine_neighbor_count_3x3_top.sv]
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+---------------------------------------
// input     | in        | in_valid / in_ready  | cell_byte
// output    | out       | out_valid / out_ready| out_row, out_col, mine_count, frame_last
// config    | in/out    | apb, pready tied high| grid_rows @ 0x0, grid_cols @ 0x4
//
// an item is accepted in idle, then the sequencer passes the upper-left and the
// upper-edge result states, issuing a result in each only where one is due; after the
// last cell of a frame it issues one flush result per column, the last with frame_last
// the single result register sets the pace: a stalled out_ready holds the sequencer
// reset clears row stores, positions and the output valid; sizes reset to one
// no memory clearing pass, the row stores are flip-flops cleared at once
module mine_neighbor_count_3x3_top (
    input  logic                         clk,
    input  logic                         rst_n,
    // apb configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mnc_pkg::APB_AW-1:0]   paddr,
    input  logic [mnc_pkg::APB_DW-1:0]   pwdata,
    output logic [mnc_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    // cell input
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [mnc_pkg::BYTE_W-1:0]   cell_byte,
    // count output
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mnc_pkg::ROW_W-1:0]    out_row,
    output logic [mnc_pkg::COL_W-1:0]    out_col,
    output logic [mnc_pkg::CNT_W-1:0]    mine_count,
    output logic                         frame_last
);
    import mnc_pkg::*;

    localparam logic [ROWS_CFG_W-1:0] ROWS_MAX = ROWS_CFG_W'(MAX_ROWS);
    localparam logic [COLS_CFG_W-1:0] COLS_MAX = COLS_CFG_W'(MAX_COLS);

    logic [ROWS_CFG_W-1:0] grid_rows_reg, grid_rows_next;
    logic [COLS_CFG_W-1:0] grid_cols_reg, grid_cols_next;
    logic                  cfg_write;
    logic                  cfg_restart;
    logic                  reg_index;
    logic [ROWS_CFG_W-1:0] wr_rows;
    logic [COLS_CFG_W-1:0] wr_cols;

    mnc_cmd_t    cmd;
    mnc_status_t status;

    // apb: zero wait states, register picked by the word address bit
    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign wr_rows   = pwdata[ROWS_CFG_W-1:0];
    assign wr_cols   = pwdata[COLS_CFG_W-1:0];

    // clamp sizes on write: zero becomes one, oversize becomes the maximum
    always_comb
    begin
        grid_rows_next = grid_rows_reg;
        grid_cols_next = grid_cols_reg;
        cfg_restart    = 1'b0;
        if (cfg_write)
        begin
            cfg_restart = 1'b1;
            case (reg_index)
                REG_GRID_ROWS:
                begin
                    if (wr_rows == '0)
                    begin
                        grid_rows_next = ROWS_CFG_W'(1);
                    end
                    else if (wr_rows > ROWS_MAX)
                    begin
                        grid_rows_next = ROWS_MAX;
                    end
                    else
                    begin
                        grid_rows_next = wr_rows;
                    end
                end
                REG_GRID_COLS:
                begin
                    if (wr_cols == '0)
                    begin
                        grid_cols_next = COLS_CFG_W'(1);
                    end
                    else if (wr_cols > COLS_MAX)
                    begin
                        grid_cols_next = COLS_MAX;
                    end
                    else
                    begin
                        grid_cols_next = wr_cols;
                    end
                end
                default:
                begin
                    cfg_restart = 1'b0;
                end
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_index)
            REG_GRID_ROWS: prdata = APB_DW'(grid_rows_reg);
            REG_GRID_COLS: prdata = APB_DW'(grid_cols_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= ROWS_CFG_W'(1);
            grid_cols_reg <= COLS_CFG_W'(1);
        end
        else
        begin
            grid_rows_reg <= grid_rows_next;
            grid_cols_reg <= grid_cols_next;
        end
    end

    // sequencer: accept, upper-left result, upper-edge result, end-of-frame flush
    mnc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // row stores, positions, window adder and result register
    mnc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cell_byte   (cell_byte),
        .grid_rows   (grid_rows_reg),
        .grid_cols   (grid_cols_reg),
        .cfg_restart (cfg_restart),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_row     (out_row),
        .out_col     (out_col),
        .mine_count  (mine_count),
        .frame_last  (frame_last)
    );

endmodule

[tb/mnc_count_checker.sv]
module mnc_count_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [mnc_pkg::APB_AW-1:0]      paddr,
    input  logic [mnc_pkg::APB_DW-1:0]      pwdata,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [mnc_pkg::BYTE_W-1:0]      cell_byte,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [mnc_pkg::ROW_W-1:0]       out_row,
    input  logic [mnc_pkg::COL_W-1:0]       out_col,
    input  logic [mnc_pkg::CNT_W-1:0]       mine_count,
    input  logic                            frame_last,
    output int                              fail_count,
    output int                              pending_counts
);
    timeunit 1ns;
    timeprecision 1ps;
    import mnc_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [CNT_W-1:0] mines;
        logic             last;
    } cell_count_t;

    cell_count_t awaited_counts[$];

    // mine bits of the two finished rows and of the row coming in
    bit [MAX_COLS-1:0] mines_two_up;
    bit [MAX_COLS-1:0] mines_up;
    bit [MAX_COLS-1:0] mines_here;
    int unsigned       cur_row;
    int unsigned       cur_col;
    int unsigned       rows_used;
    int unsigned       cols_used;

    function automatic int unsigned mine_bit(input bit [MAX_COLS-1:0] line, input int col);
        if (col < 0 || col >= int'(cols_used))
            return 0;
        return line[col];
    endfunction

    function automatic int unsigned window_mines(
        input bit [MAX_COLS-1:0] top,
        input bit [MAX_COLS-1:0] mid,
        input bit [MAX_COLS-1:0] bot,
        input int                col
    );
        int unsigned sum = 0;
        for (int dc = -1; dc <= 1; dc++)
            sum += mine_bit(top, col + dc) + mine_bit(mid, col + dc) + mine_bit(bot, col + dc);
        return sum;
    endfunction

    function automatic void push_count(input int unsigned r, input int unsigned c,
                                       input int unsigned m, input bit last);
        cell_count_t e;
        e.row   = ROW_W'(r);
        e.col   = COL_W'(c);
        e.mines = CNT_W'(m);
        e.last  = last;
        awaited_counts.push_back(e);
    endfunction

    function automatic void restart_grid();
        mines_two_up = '0;
        mines_up     = '0;
        mines_here   = '0;
        cur_row      = 0;
        cur_col      = 0;
    endfunction

    function automatic void write_register(input logic [APB_AW-1:0] addr,
                                           input logic [APB_DW-1:0] data);
        int unsigned v;
        if ((addr >> 2) == REG_GRID_ROWS)
        begin
            v = data[ROWS_CFG_W-1:0];
            rows_used = (v == 0) ? 1 : (v > MAX_ROWS ? MAX_ROWS : v);
            restart_grid();
        end
        else if ((addr >> 2) == REG_GRID_COLS)
        begin
            v = data[COLS_CFG_W-1:0];
            cols_used = (v == 0) ? 1 : (v > MAX_COLS ? MAX_COLS : v);
            restart_grid();
        end
    endfunction

    // one cell in: counts of the row above become final behind it
    function automatic void absorb_cell(input logic [BYTE_W-1:0] value);
        int unsigned r;
        int unsigned c;
        int unsigned last_col;
        r        = cur_row;
        c        = cur_col;
        last_col = cols_used - 1;
        mines_here[c] = (value == MINE_BYTE);
        if (r >= 1)
        begin
            if (c >= 1)
                push_count(r - 1, c - 1,
                           window_mines(mines_two_up, mines_up, mines_here, c - 1), 0);
            if (c == last_col)
                push_count(r - 1, c,
                           window_mines(mines_two_up, mines_up, mines_here, c), 0);
        end
        if (c >= last_col)
        begin
            if (r + 1 >= rows_used)
            begin
                for (int j = 0; j < int'(cols_used); j++)
                    push_count(r, j, window_mines(mines_up, mines_here, '0, j), j == last_col);
                restart_grid();
            end
            else
            begin
                mines_two_up = mines_up;
                mines_up     = mines_here;
                mines_here   = '0;
                cur_row      = r + 1;
                cur_col      = 0;
            end
        end
        else
            cur_col = c + 1;
    endfunction

    function automatic void check_count();
        cell_count_t seen;
        cell_count_t want;
        seen.row   = out_row;
        seen.col   = out_col;
        seen.mines = mine_count;
        seen.last  = frame_last;
        if (awaited_counts.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected count: expected none, got row %0d col %0d mines %0d last %0b",
                         seen.row, seen.col, seen.mines, seen.last);
        end
        else
        begin
            want = awaited_counts.pop_front();
            if (seen.row !== want.row || seen.col !== want.col ||
                seen.mines !== want.mines || seen.last !== want.last)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("count mismatch: expected row %0d col %0d mines %0d last %0b",
                             want.row, want.col, want.mines, want.last);
                    $display("                got row %0d col %0d mines %0d last %0b",
                             seen.row, seen.col, seen.mines, seen.last);
                end
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used = 1;
            cols_used = 1;
            restart_grid();
            awaited_counts.delete();
            fail_count     = 0;
            pending_counts = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                write_register(paddr, pwdata);
            if (in_valid && in_ready)
                absorb_cell(cell_byte);
            if (out_valid && out_ready)
                check_count();
            pending_counts = awaited_counts.size();
        end
    end

endmodule

[tb/mine_neighbor_count_3x3_top_test.sv]
module mine_neighbor_count_3x3_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mnc_pkg::*;

    // register addresses, one word per register
    localparam logic [APB_AW-1:0] ADDR_GRID_ROWS = APB_AW'({REG_GRID_ROWS, 2'b00});
    localparam logic [APB_AW-1:0] ADDR_GRID_COLS = APB_AW'({REG_GRID_COLS, 2'b00});

    // extra settle time in the drain after every predicted count has arrived
    localparam int SETTLE_CYCLES   = 40;
    // least number of random items per idling phase
    localparam int PHASE_ITEMS     = 12;
    // receiver hold-off long enough to back the block up into its input
    localparam int LONG_HOLD       = 400;
    localparam int CYCLE_LIMIT     = 500000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [APB_AW-1:0] paddr     = '0;
    logic [APB_DW-1:0] pwdata    = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [BYTE_W-1:0] cell_byte = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_col;
    logic [CNT_W-1:0]  mine_count;
    logic              frame_last;

    int fail_count;
    int pending_counts;

    // idling odds in percent, set per phase by the stimulus
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    // long hold-off requests: the receiver acts when these differ
    int unsigned hold_reqs = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    int unsigned items_sent     = 0;
    int unsigned grid_rows_eff  = 1;
    int unsigned grid_cols_eff  = 1;
    int unsigned cycles         = 0;

    always #5 clk = ~clk;

    mine_neighbor_count_3x3_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cell_byte  (cell_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_row    (out_row),
        .out_col    (out_col),
        .mine_count (mine_count),
        .frame_last (frame_last)
    );

    // watches every channel, predicts the counts and scores them
    mnc_count_checker u_count_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cell_byte      (cell_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_row        (out_row),
        .out_col        (out_col),
        .mine_count     (mine_count),
        .frame_last     (frame_last),
        .fail_count     (fail_count),
        .pending_counts (pending_counts)
    );

    // receiver: random back-pressure, or a long hold-off counted here when asked
    always @(posedge clk)
    begin
        if (hold_reqs != hold_seen)
        begin
            hold_seen <= hold_reqs;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // offer one item, with random gaps in front; valid stays up between
    // back-to-back items and is only lowered in a gap or by the drain
    task automatic send_cell(input logic [BYTE_W-1:0] value);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cell_byte <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // stop offering, wait for every predicted count, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_counts != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write: setup cycle then access cycle
    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int unsigned fit_size(input int unsigned v, input int unsigned top);
        return (v == 0) ? 1 : (v > top ? top : v);
    endfunction

    // size fields with junk in the unused upper bits; out-of-range sizes clamp
    task automatic set_grid(input int unsigned rows_raw, input int unsigned cols_raw);
        write_reg(ADDR_GRID_ROWS, ($urandom() << ROWS_CFG_W) | rows_raw);
        write_reg(ADDR_GRID_COLS, ($urandom() << COLS_CFG_W) | cols_raw);
        grid_rows_eff = fit_size(rows_raw, MAX_ROWS);
        grid_cols_eff = fit_size(cols_raw, MAX_COLS);
    endtask

    // a mine with the given odds in percent, else a near miss one bit off the mine byte or any byte
    function automatic logic [BYTE_W-1:0] random_cell(input int unsigned density);
        logic [BYTE_W-1:0] b;
        if ($urandom_range(99) < density)
            return MINE_BYTE;
        b = ($urandom_range(3) == 0) ? (MINE_BYTE ^ (8'h01 << $urandom_range(7)))
                                     : BYTE_W'($urandom());
        return b;
    endfunction

    task automatic send_frame(input int unsigned n_items, input int unsigned density);
        for (int unsigned i = 0; i < n_items; i++)
            send_cell(random_cell(density));
    endtask

    // whole random frames of random size, now and then cut short and restarted
    task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                             input bit long_hold);
        int unsigned first_item;
        int unsigned n_items;
        int unsigned rows_raw;
        int unsigned cols_raw;
        bit          need_cfg;
        first_item  = items_sent;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        need_cfg    = 1'b1;
        if (long_hold)
            hold_reqs++;
        while (items_sent - first_item < PHASE_ITEMS)
        begin
            if (need_cfg || $urandom_range(1) == 0)
            begin
                drain();
                case ($urandom_range(7))
                    0:
                    begin
                        // one full-width row, wide values clamp to the maximum
                        rows_raw = 1;
                        cols_raw = $urandom_range(63, 32);
                    end
                    1:
                    begin
                        rows_raw = $urandom_range(6, 2);
                        cols_raw = 1;
                    end
                    2:
                    begin
                        // zero rows counts as one
                        rows_raw = 0;
                        cols_raw = $urandom_range(5, 2);
                    end
                    default:
                    begin
                        rows_raw = $urandom_range(5, 1);
                        cols_raw = $urandom_range(6, 1);
                    end
                endcase
                set_grid(rows_raw, cols_raw);
            end
            n_items  = grid_rows_eff * grid_cols_eff;
            need_cfg = 1'b0;
            // broken frame: stop part way, the next size write restarts it
            if (n_items > 1 && $urandom_range(7) == 0)
            begin
                n_items  = $urandom_range(n_items - 1, 1);
                need_cfg = 1'b1;
            end
            send_frame(n_items, $urandom_range(80, 10));
        end
        drain();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        tx_idle_pct = 9;
        rx_idle_pct = 81;

        // reset sizes are 1x1: every item is a whole frame of its own
        send_cell(MINE_BYTE);
        send_cell(8'h00);
        send_cell(8'hFF);
        send_cell(8'h20);
        send_cell(8'hA1);
        drain();

        // zero sizes fall back to one
        set_grid(0, 0);
        send_cell(MINE_BYTE);
        send_cell(8'h22);
        drain();

        // full 3x3 of mines: corners 4, edges 6, centre 9
        set_grid(3, 3);
        send_frame(9, 100);
        drain();

        // single row and single column, missing neighbours count as empty
        set_grid(1, 4);
        send_cell(MINE_BYTE);
        send_cell(8'h2E);
        send_cell(MINE_BYTE);
        send_cell(MINE_BYTE);
        drain();
        set_grid(4, 1);
        send_cell(MINE_BYTE);
        send_cell(MINE_BYTE);
        send_cell(8'h01);
        send_cell(MINE_BYTE);
        drain();

        run_phase(9, 81, 1'b0);
        run_phase(81, 9, 1'b0);

        // largest grid, clamped from oversized values: a row and a bit, then abandoned
        set_grid(2047, 63);
        send_frame(40, 40);
        drain();

        // no idling, with one long receiver hold-off at the start
        run_phase(0, 0, 1'b1);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
